// ===== hdl/rpws_pkg.sv =====
// ----------------------------------------------------------------------------
// rpws_pkg
// Shared types, constants and helpers for the RGB pixel to pulse symbol
// encoder.
// ----------------------------------------------------------------------------
package rpws_pkg;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic       first_level;
    logic [7:0] first_ticks;
    logic       second_level;
    logic [7:0] second_ticks;
    logic       last_symbol;
  } symbol_t;

  // Scaled channels in wire order
  typedef struct packed {
    logic [7:0] green;
    logic [7:0] red;
    logic [7:0] blue;
  } grb_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  localparam int unsigned DataBits       = 24;
  localparam int unsigned SymbolCount    = DataBits + 1;
  localparam int unsigned CountWidth     = $clog2(SymbolCount);
  localparam logic [CountWidth-1:0] LastIdx = CountWidth'(DataBits);

  localparam logic [7:0] OneHighTicks    = 8'd9;
  localparam logic [7:0] OneLowTicks     = 8'd3;
  localparam logic [7:0] ZeroHighTicks   = 8'd3;
  localparam logic [7:0] ZeroLowTicks    = 8'd9;
  localparam int unsigned TickHz         = 10000000;
  localparam int unsigned ResetUs        = 50;
  localparam logic [7:0] ResetHalfTicks  = 8'((TickHz / 1000000) * ResetUs / 2);
  localparam logic [7:0] BrightnessReset = 8'd64;
  localparam logic [7:0] FullScale       = 8'd255;

  // Exact p / 255 for any 16-bit p below 65535, then clamp to one byte
  function automatic logic [7:0] scale_div(input logic [15:0] p);
    logic [16:0] s;
    logic [8:0]  q;
    s = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
    q = s[16:8];
    scale_div = (q > {1'b0, FullScale}) ? FullScale : q[7:0];
  endfunction

endpackage

// ===== hdl/rgb_pixel_to_ws2812_symbols_core.sv =====
// ----------------------------------------------------------------------------
// rgb_pixel_to_ws2812_symbols_core
// RGB pixel to LED pulse symbol encoder with brightness scaling.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on pixel / pixel_valid / pixel_stall; a transaction takes
//   place on a clock edge with valid high and stall low. Each pixel yields
//   25 symbols on symbol / symbol_valid / symbol_stall: 24 data symbols
//   (green, red, blue, MSB first) and one reset symbol flagged last_symbol.
//   brightness_wr loads brightness_data into the scale register; write it
//   only while no pixel is in flight.
// Path: the first symbol of a pixel passes through the multiply stage, the
//   queue, the serializer word register and the output register.
// Throughput: the symbol serializer emits one symbol per cycle while
//   symbol_stall does not hold it; a two-entry queue lets the front keep
//   accepting pixels while the serializer works.
// Reset: rst (synchronous) empties the pipeline and queue and sets
//   brightness to 64.
// Stall: a stalled symbol holds in the output register; the serializer
//   freezes, then the queue fills and pixel_stall rises.
// ----------------------------------------------------------------------------
module rgb_pixel_to_ws2812_symbols_core (
  input  logic              clk,
  input  logic              rst,
  input  rpws_pkg::pixel_t  pixel,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  output rpws_pkg::symbol_t symbol,
  output logic              symbol_valid,
  input  logic              symbol_stall,
  input  logic              brightness_wr,
  input  logic [7:0]        brightness_data
);

  rpws_pkg::queue_status_t qstat;
  rpws_pkg::grb_t          push_data;
  rpws_pkg::grb_t          pop_data;
  logic                    push;
  logic                    pop;

  rpws_front u_front (
    .clk             (clk),
    .rst             (rst),
    .pixel           (pixel),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .brightness_wr   (brightness_wr),
    .brightness_data (brightness_data),
    .qstat           (qstat),
    .push            (push),
    .push_data       (push_data)
  );

  rpws_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .qstat     (qstat)
  );

  rpws_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .pop          (pop),
    .pop_data     (pop_data),
    .symbol       (symbol),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall)
  );

  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(qstat.full && qstat.empty))
    else $error("queue reports full and empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !qstat.full)
    else $error("push into full queue");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> qstat.full)
    else $error("pixel stalled with queue space");

  a_reset_symbol: assert property (@(posedge clk) disable iff (rst)
    (symbol_valid && symbol.last_symbol) |->
      (!symbol.first_level && symbol.first_ticks == rpws_pkg::ResetHalfTicks))
    else $error("bad closing symbol");

  a_data_symbol: assert property (@(posedge clk) disable iff (rst)
    (symbol_valid && !symbol.last_symbol) |->
      (symbol.first_level && (symbol.first_ticks == rpws_pkg::OneHighTicks ||
                              symbol.first_ticks == rpws_pkg::ZeroHighTicks)))
    else $error("bad data symbol");

endmodule

// ===== hdl/rpws_front.sv =====
// ----------------------------------------------------------------------------
// rpws_front
// Accepts pixels, scales each channel by brightness and pushes the
// reordered green/red/blue word into the symbol queue.
// ----------------------------------------------------------------------------
module rpws_front (
  input  logic                   clk,
  input  logic                   rst,
  input  rpws_pkg::pixel_t       pixel,
  input  logic                   pixel_valid,
  output logic                   pixel_stall,
  input  logic                   brightness_wr,
  input  logic [7:0]             brightness_data,
  input  rpws_pkg::queue_status_t qstat,
  output logic                   push,
  output rpws_pkg::grb_t         push_data
);

  logic [7:0]  brightness;
  logic        prod_valid;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic        accept;

  assign pixel_stall = prod_valid && qstat.full;
  assign accept      = pixel_valid && !pixel_stall;
  assign push        = prod_valid && !qstat.full;

  assign push_data.green = rpws_pkg::scale_div(prod_g);
  assign push_data.red   = rpws_pkg::scale_div(prod_r);
  assign push_data.blue  = rpws_pkg::scale_div(prod_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= rpws_pkg::BrightnessReset;
      prod_valid <= 1'b0;
    end else begin
      if (brightness_wr) begin
        brightness <= brightness_data;
      end
      if (accept) begin
        prod_valid <= 1'b1;
      end else if (push) begin
        prod_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prod_r <= 16'(pixel.red)   * 16'(brightness);
      prod_g <= 16'(pixel.green) * 16'(brightness);
      prod_b <= 16'(pixel.blue)  * 16'(brightness);
    end
  end

endmodule

// ===== hdl/rpws_queue.sv =====
// ----------------------------------------------------------------------------
// rpws_queue
// Two-entry queue of scaled pixel words between front and back.
// ----------------------------------------------------------------------------
module rpws_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rpws_pkg::grb_t          push_data,
  input  logic                    pop,
  output rpws_pkg::grb_t          pop_data,
  output rpws_pkg::queue_status_t qstat
);

  rpws_pkg::grb_t entries [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  assign qstat.full  = (count == 2'd2);
  assign qstat.empty = (count == 2'd0);
  assign pop_data    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/rpws_back.sv =====
// ----------------------------------------------------------------------------
// rpws_back
// Serializes one scaled word into 24 data symbols and a closing reset
// symbol, one symbol per cycle unless the output stalls, through a registered output.
// ----------------------------------------------------------------------------
module rpws_back (
  input  logic                    clk,
  input  logic                    rst,
  input  rpws_pkg::queue_status_t qstat,
  output logic                    pop,
  input  rpws_pkg::grb_t          pop_data,
  output rpws_pkg::symbol_t       symbol,
  output logic                    symbol_valid,
  input  logic                    symbol_stall
);

  logic                              busy;
  logic [rpws_pkg::DataBits-1:0]     word;
  logic [rpws_pkg::CountWidth-1:0]   cnt;
  logic                              emit;
  logic                              at_last;
  rpws_pkg::symbol_t                 sym;

  assign at_last = (cnt == rpws_pkg::LastIdx);
  assign emit    = busy && (!symbol_valid || !symbol_stall);
  // Load the next word in the same cycle the reset symbol enters the output register
  assign pop     = !qstat.empty && (!busy || (emit && at_last));

  always_comb begin
    sym.last_symbol  = 1'b0;
    sym.first_level  = 1'b1;
    sym.second_level = 1'b0;
    if (at_last) begin
      sym.first_level  = 1'b0;
      sym.first_ticks  = rpws_pkg::ResetHalfTicks;
      sym.second_ticks = rpws_pkg::ResetHalfTicks;
      sym.last_symbol  = 1'b1;
    end else if (word[rpws_pkg::DataBits-1]) begin
      sym.first_ticks  = rpws_pkg::OneHighTicks;
      sym.second_ticks = rpws_pkg::OneLowTicks;
    end else begin
      sym.first_ticks  = rpws_pkg::ZeroHighTicks;
      sym.second_ticks = rpws_pkg::ZeroLowTicks;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      cnt          <= '0;
      symbol_valid <= 1'b0;
    end else begin
      if (emit) begin
        symbol_valid <= 1'b1;
      end else if (!symbol_stall) begin
        symbol_valid <= 1'b0;
      end
      if (pop) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (emit) begin
        if (at_last) begin
          busy <= 1'b0;
          cnt  <= '0;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      symbol <= sym;
    end
    if (pop) begin
      word <= pop_data;
    end else if (emit) begin
      word <= {word[rpws_pkg::DataBits-2:0], 1'b0};
    end
  end

endmodule

// ===== bench/tb_rgb_pixel_to_ws2812_symbols_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rgb_pixel_to_ws2812_symbols_core
// Self-checking bench for the pixel to LED pulse symbol encoder.
// A table of directed pixels covers the reset brightness, full and zero scale,
// channel reordering and every bit position. Random pixels then run under
// several brightness settings. Every accepted pixel is expanded into its 25
// symbols by a local scaling and encoding model. Each symbol is checked field
// by field as it leaves the block. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_rgb_pixel_to_ws2812_symbols_core;

  localparam int unsigned QuietLimit    = 4000;
  localparam int unsigned RandomPixels  = 224;
  localparam int unsigned PhasePixels   = 28;
  localparam int unsigned PatternCount  = 14;

  typedef struct packed {
    logic        set_gain;
    logic [7:0]  gain;
    logic [23:0] rgb;
    logic        typed;
    logic [23:0] grb;
  } pattern_row_t;

  typedef struct {
    bit             typed;
    rpws_pkg::grb_t grb;
  } grb_hint_t;

  // Directed pixels: rgb is red/green/blue, grb is the scaled wire order
  localparam pattern_row_t Patterns [PatternCount] = '{
    '{1'b0, 8'd0,   24'hFFFFFF, 1'b1, 24'h404040},   // reset brightness
    '{1'b0, 8'd0,   24'h000000, 1'b1, 24'h000000},
    '{1'b1, 8'd255, 24'hFFFFFF, 1'b1, 24'hFFFFFF},   // full scale passes through
    '{1'b0, 8'd0,   24'hAA550F, 1'b1, 24'h55AA0F},
    '{1'b0, 8'd0,   24'h55AAF0, 1'b1, 24'hAA55F0},
    '{1'b0, 8'd0,   24'h01807F, 1'b1, 24'h80017F},
    '{1'b0, 8'd0,   24'h123456, 1'b1, 24'h341256},
    '{1'b1, 8'd0,   24'hFFFFFF, 1'b1, 24'h000000},   // dark: all zero bits
    '{1'b0, 8'd0,   24'h5AA53C, 1'b1, 24'h000000},
    '{1'b1, 8'd128, 24'hFF8001, 1'b0, 24'h000000},
    '{1'b0, 8'd0,   24'h7FFE02, 1'b0, 24'h000000},
    '{1'b1, 8'd1,   24'hFFFE80, 1'b0, 24'h000000},
    '{1'b1, 8'd254, 24'hFF807F, 1'b0, 24'h000000},
    '{1'b1, 8'd200, 24'hC86432, 1'b0, 24'h000000}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  rpws_pkg::pixel_t  pixel = '0;
  logic              pixel_valid = 1'b0;
  logic              pixel_stall;
  rpws_pkg::symbol_t symbol;
  logic              symbol_valid;
  logic              symbol_stall = 1'b0;
  logic              brightness_wr = 1'b0;
  logic [7:0]        brightness_data = '0;

  rpws_pkg::symbol_t pending_symbols[$];
  grb_hint_t         shade_hints[$];
  logic [7:0]        gain_model;
  bit                idling_on = 1'b1;
  int unsigned       quiet_cycles = 0;
  int unsigned       error_count = 0;
  int unsigned       pixels_sent = 0;
  int unsigned       symbols_checked = 0;
  int unsigned       gain_writes = 0;

  rgb_pixel_to_ws2812_symbols_core dut (
    .clk             (clk),
    .rst             (rst),
    .pixel           (pixel),
    .pixel_valid     (pixel_valid),
    .pixel_stall     (pixel_stall),
    .symbol          (symbol),
    .symbol_valid    (symbol_valid),
    .symbol_stall    (symbol_stall),
    .brightness_wr   (brightness_wr),
    .brightness_data (brightness_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("[%0t] mismatch: %s (symbol %0d of pixel stream) got %0d want %0d",
             $realtime, what, symbols_checked % rpws_pkg::SymbolCount, got, want);
  endtask

  function automatic logic [7:0] apply_gain(input logic [7:0] level, input logic [7:0] gain);
    int unsigned prod;
    prod = (32'(level) * 32'(gain)) / 255;
    return (prod > 255) ? 8'hFF : prod[7:0];
  endfunction

  function automatic rpws_pkg::grb_t scale_pixel(input rpws_pkg::pixel_t px,
                                                 input logic [7:0] gain);
    rpws_pkg::grb_t g;
    g.green = apply_gain(px.green, gain);
    g.red   = apply_gain(px.red, gain);
    g.blue  = apply_gain(px.blue, gain);
    return g;
  endfunction

  // Expand one scaled pixel into its data symbols plus the closing reset symbol
  task automatic queue_frame(input rpws_pkg::grb_t g);
    logic [23:0]       bits;
    rpws_pkg::symbol_t s;
    bits = g;
    for (int i = 23; i >= 0; i--) begin
      s.first_level  = 1'b1;
      s.first_ticks  = bits[i] ? rpws_pkg::OneHighTicks : rpws_pkg::ZeroHighTicks;
      s.second_level = 1'b0;
      s.second_ticks = bits[i] ? rpws_pkg::OneLowTicks : rpws_pkg::ZeroLowTicks;
      s.last_symbol  = 1'b0;
      pending_symbols.push_back(s);
    end
    s.first_level  = 1'b0;
    s.first_ticks  = rpws_pkg::ResetHalfTicks;
    s.second_level = 1'b0;
    s.second_ticks = rpws_pkg::ResetHalfTicks;
    s.last_symbol  = 1'b1;
    pending_symbols.push_back(s);
  endtask

  // Monitor: predict on pixel transactions, check on symbol transactions
  always @(posedge clk) begin
    grb_hint_t         hint;
    rpws_pkg::symbol_t want;
    if (rst) begin
      gain_model = rpws_pkg::BrightnessReset;
      quiet_cycles = 0;
    end else begin
      if (brightness_wr) begin
        gain_model = brightness_data;
      end
      if (pixel_valid && !pixel_stall) begin
        hint = shade_hints.pop_front();
        queue_frame(hint.typed ? hint.grb : scale_pixel(pixel, gain_model));
      end
      if (symbol_valid && !symbol_stall) begin
        if (pending_symbols.size() == 0) begin
          report_mismatch("symbol with nothing expected", int'(symbol), 0);
        end else begin
          want = pending_symbols.pop_front();
          if (symbol.first_level !== want.first_level)
            report_mismatch("first_level", int'(symbol.first_level),
                            int'(want.first_level));
          if (symbol.first_ticks !== want.first_ticks)
            report_mismatch("first_ticks", int'(symbol.first_ticks),
                            int'(want.first_ticks));
          if (symbol.second_level !== want.second_level)
            report_mismatch("second_level", int'(symbol.second_level),
                            int'(want.second_level));
          if (symbol.second_ticks !== want.second_ticks)
            report_mismatch("second_ticks", int'(symbol.second_ticks),
                            int'(want.second_ticks));
          if (symbol.last_symbol !== want.last_symbol)
            report_mismatch("last_symbol", int'(symbol.last_symbol),
                            int'(want.last_symbol));
          symbols_checked++;
        end
      end
      if ((pixel_valid && !pixel_stall) || (symbol_valid && !symbol_stall))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Symbol sink: stall at random while idling is enabled
  always @(posedge clk) begin
    symbol_stall <= idling_on && ($urandom_range(99) < 14);
  end

  task automatic send_pixel(input rpws_pkg::pixel_t px, input bit typed,
                            input rpws_pkg::grb_t grb);
    grb_hint_t hint;
    if (idling_on && ($urandom_range(99) < 14)) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    hint.typed = typed;
    hint.grb   = grb;
    shade_hints.push_back(hint);
    pixel       <= px;
    pixel_valid <= 1'b1;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Wait for every expected symbol, then load the new brightness
  task automatic drain_and_set_gain(input logic [7:0] gain);
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending_symbols.size() != 0) @(posedge clk);
    brightness_wr   <= 1'b1;
    brightness_data <= gain;
    @(posedge clk);
    brightness_wr <= 1'b0;
    gain_writes++;
  endtask

  function automatic logic [7:0] pick_channel();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h80;
      3:       return 8'h01;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    while (quiet_cycles < QuietLimit) @(posedge clk);
    $display("timeout: no transaction for %0d cycles, %0d symbols outstanding",
             QuietLimit, pending_symbols.size());
    $display("rgb_pixel_to_ws2812_symbols_core regression: fail");
    $finish;
  end

  initial begin
    rpws_pkg::pixel_t px;
    logic [7:0]       gain;
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < PatternCount; i++) begin
      if (Patterns[i].set_gain) drain_and_set_gain(Patterns[i].gain);
      send_pixel(rpws_pkg::pixel_t'(Patterns[i].rgb), Patterns[i].typed,
                 rpws_pkg::grb_t'(Patterns[i].grb));
    end

    for (int phase = 0; phase < RandomPixels / PhasePixels; phase++) begin
      case (phase)
        0:       gain = 8'd255;
        1:       gain = 8'd0;
        3:       gain = 8'd1;
        5:       gain = 8'd128;
        default: gain = 8'($urandom_range(2, 253));
      endcase
      drain_and_set_gain(gain);
      // one phase runs back to back with no idling on either side
      idling_on = (phase != 4);
      for (int n = 0; n < PhasePixels; n++) begin
        px.red   = pick_channel();
        px.green = pick_channel();
        px.blue  = pick_channel();
        send_pixel(px, 1'b0, '0);
      end
    end
    idling_on = 1'b1;

    pixel_valid <= 1'b0;
    @(posedge clk);
    while (pending_symbols.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (pending_symbols.size() != 0)
      report_mismatch("symbols never delivered", 0, pending_symbols.size());

    $display("covered %0d pixels under %0d brightness loads, %0d symbols checked",
             pixels_sent, gain_writes, symbols_checked);
    $display("mismatches: %0d", error_count);
    if (error_count == 0) begin
      $display("rgb_pixel_to_ws2812_symbols_core regression: pass");
    end else begin
      $display("rgb_pixel_to_ws2812_symbols_core regression: fail");
    end
    $finish;
  end

endmodule
